// ----- sv/pbs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pbs_pkg;

   localparam int PRIO_SLOTS = 32;

   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_BLOCK = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;
   localparam logic [1:0] OP_SCHED = 2'd3;

   typedef struct packed {
      logic [1:0]  operation;
      logic [5:0]  priority_req;
      logic [31:0] delay_ticks;
   } req_type;

   typedef struct packed {
      logic [5:0]  next_priority;
      logic        switch_request;
      logic        start_accepted;
      logic [31:0] ready_bits;
      logic [31:0] blocked_bits;
   } rsp_type;

   // Highest set bit plus one, or zero when the mask is empty.
   function automatic logic [5:0] top_priority(input logic [31:0] mask);
      logic [5:0] p;
      p = 6'd0;
      for (int i = 0; i < PRIO_SLOTS; i++) begin
         if (mask[i]) begin
            p = 6'(i + 1);
         end
      end
      return p;
   endfunction

endpackage

`default_nettype wire

// ----- sv/pbs_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                                    clock,
   input  wire logic                                    wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                        wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ----- sv/priority_bitmap_scheduler_with_delays.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Start, block and schedule words go from the idle state to the finish state, which loads
// the result register once the output is free. A tick word walks the delay counter memory
// one entry a cycle through a single decrement unit and a read-modify-write pipeline.
// One word is in work at a time; a finished result may wait in the output register.
// Synchronous reset clears the masks, the running thread, the state and all control flags.
// The delay counter memory is not cleared; a tick reads every entry, but one is only used after a block writes it.

module priority_bitmap_scheduler_with_delays
   import pbs_pkg::*;
#(
   parameter int NUM_PRIORITIES = 32,
   parameter int DELAY_WIDTH    = 32
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int IDX_W = (NUM_PRIORITIES > 1) ? $clog2(NUM_PRIORITIES) : 1;
   localparam logic [31:0] PRIO_MASK = (NUM_PRIORITIES >= 32) ? 32'hFFFF_FFFF :
      32'((64'd1 << NUM_PRIORITIES) - 64'd1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PRIORITIES - 1);
   localparam logic [5:0] NUM_PRIO6 = 6'(NUM_PRIORITIES);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [31:0]            ready_ff, ready_in;
   logic [31:0]            blocked_ff, blocked_in;
   logic [32:0]            started_ff, started_in;
   logic [5:0]             running_ff, running_in;
   logic                   run_vld_ff, run_vld_in;
   logic                   sched_ff, sched_in;
   logic                   acc_ff, acc_in;
   logic                   rd_on_ff, rd_on_in;
   logic [IDX_W-1:0]       rd_idx_ff, rd_idx_in;
   logic                   stg_vld_ff, stg_vld_in;
   logic [IDX_W-1:0]       stg_idx_ff, stg_idx_in;
   logic                   rsp_vld_ff, rsp_vld_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   accept;
   logic                   out_free;
   logic                   start_ok;
   logic                   block_ok;
   logic [63:0]            delay_ext;
   logic [5:0]             run_m1;
   logic [5:0]             req_m1;
   logic [5:0]             chosen;
   logic [DELAY_WIDTH-1:0] dec;
   logic [31:0]            stg_bit;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   logic [DELAY_WIDTH-1:0] wr_data;
   logic [DELAY_WIDTH-1:0] rd_data;

   pbs_ram #(
      .WIDTH(DELAY_WIDTH),
      .DEPTH(NUM_PRIORITIES)
   ) u_delay_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_idx_ff),
      .rd_data(rd_data)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_vld_ff || !rsp_stall;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   assign delay_ext = 64'(req_data.delay_ticks);
   assign run_m1    = running_ff - 6'd1;
   assign req_m1    = req_data.priority_req - 6'd1;
   assign start_ok  = (req_data.priority_req <= NUM_PRIO6) &&
                      !(|(started_ff & (33'd1 << req_data.priority_req)));
   assign block_ok  = run_vld_ff && (running_ff != 6'd0);
   assign chosen    = top_priority(ready_ff & PRIO_MASK);
   assign dec       = rd_data - DELAY_WIDTH'(1);
   assign stg_bit   = 32'd1 << stg_idx_ff;

   always_comb begin
      state_in   = state_ff;
      ready_in   = ready_ff;
      blocked_in = blocked_ff;
      started_in = started_ff;
      running_in = running_ff;
      run_vld_in = run_vld_ff;
      sched_in   = sched_ff;
      acc_in     = acc_ff;
      rd_on_in   = rd_on_ff;
      rd_idx_in  = rd_idx_ff;
      stg_vld_in = stg_vld_ff;
      stg_idx_in = stg_idx_ff;
      rsp_vld_in = rsp_vld_ff && rsp_stall;
      rsp_in     = rsp_ff;
      wr_en      = 1'b0;
      wr_addr    = stg_idx_ff;
      wr_data    = dec;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               sched_in = 1'b0;
               acc_in   = 1'b0;
               state_in = ST_FINISH;
               case (req_data.operation)
                  OP_START: begin
                     if (start_ok) begin
                        acc_in     = 1'b1;
                        started_in = started_ff | (33'd1 << req_data.priority_req);
                        if (req_data.priority_req != 6'd0) begin
                           ready_in = ready_ff | ((32'd1 << req_m1) & PRIO_MASK);
                        end
                     end
                  end
                  OP_BLOCK: begin
                     if (block_ok) begin
                        sched_in   = 1'b1;
                        wr_en      = 1'b1;
                        wr_addr    = run_m1[IDX_W-1:0];
                        wr_data    = delay_ext[DELAY_WIDTH-1:0];
                        ready_in   = ready_ff & ~(32'd1 << run_m1);
                        blocked_in = blocked_ff | (32'd1 << run_m1);
                     end
                  end
                  OP_TICK: begin
                     sched_in   = 1'b1;
                     rd_on_in   = 1'b1;
                     rd_idx_in  = '0;
                     stg_vld_in = 1'b0;
                     state_in   = ST_SCAN;
                  end
                  default: begin
                     sched_in = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            stg_vld_in = rd_on_ff;
            stg_idx_in = rd_idx_ff;
            if (rd_on_ff) begin
               if (rd_idx_ff == LAST_IDX) begin
                  rd_on_in = 1'b0;
               end else begin
                  rd_idx_in = rd_idx_ff + IDX_W'(1);
               end
            end
            if (stg_vld_ff && blocked_ff[stg_idx_ff]) begin
               wr_en = 1'b1;
               if (dec == '0) begin
                  blocked_in = blocked_ff & ~stg_bit;
                  ready_in   = ready_ff | stg_bit;
               end
            end
            if (!rd_on_ff && stg_vld_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_vld_in                = 1'b1;
               rsp_in.start_accepted     = acc_ff;
               rsp_in.ready_bits         = ready_ff;
               rsp_in.blocked_bits       = blocked_ff;
               if (sched_ff) begin
                  rsp_in.next_priority  = chosen;
                  rsp_in.switch_request = !run_vld_ff || (chosen != running_ff);
                  running_in            = chosen;
                  run_vld_in            = 1'b1;
               end else begin
                  rsp_in.next_priority  = running_ff;
                  rsp_in.switch_request = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         ready_ff   <= '0;
         blocked_ff <= '0;
         started_ff <= '0;
         running_ff <= '0;
         run_vld_ff <= 1'b0;
         sched_ff   <= 1'b0;
         acc_ff     <= 1'b0;
         rd_on_ff   <= 1'b0;
         stg_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         ready_ff   <= ready_in;
         blocked_ff <= blocked_in;
         started_ff <= started_in;
         running_ff <= running_in;
         run_vld_ff <= run_vld_in;
         sched_ff   <= sched_in;
         acc_ff     <= acc_in;
         rd_on_ff   <= rd_on_in;
         stg_vld_ff <= stg_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff  <= rd_idx_in;
      stg_idx_ff <= stg_idx_in;
      rsp_ff     <= rsp_in;
   end

   a_masks_disjoint: assert property (@(posedge clock) disable iff (reset)
      (ready_ff & blocked_ff) == 32'd0)
      else $error("A priority is both ready and blocked.");

   a_masks_in_range: assert property (@(posedge clock) disable iff (reset)
      ((ready_ff | blocked_ff) & ~PRIO_MASK) == 32'd0)
      else $error("A mask bit lies above the highest priority.");

   a_running_in_range: assert property (@(posedge clock) disable iff (reset)
      running_ff <= NUM_PRIO6)
      else $error("The running priority lies above the highest priority.");

   a_tick_scans: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.operation == OP_TICK)) |=> (state_ff == ST_SCAN) && rd_on_ff)
      else $error("A tick word did not start the counter walk.");

   a_scan_no_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) && !rsp_vld_ff |=> !rsp_vld_ff)
      else $error("A result appeared during the counter walk.");

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import pbs_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int RANDOM_WORDS = 1000;
   localparam int DRAIN_CYCLES = 40;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   priority_bitmap_scheduler_with_delays u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   req_type     words_to_send[$];
   rsp_type     decisions_due[$];
   rsp_type     due;
   int          total_words = 0;
   int          words_sent = 0;
   int          quiet_cycles = 0;
   int          failures = 0;
   bit          timed_out = 1'b0;

   logic [31:0] ready_set = '0;
   logic [31:0] blocked_set = '0;
   logic [32:0] started_set = '0;
   logic [31:0] ticks_left [PRIO_SLOTS];
   logic [5:0]  running_prio = '0;
   logic        running_known = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic rsp_type apply_operation(input req_type w);
      rsp_type    r;
      logic [5:0] chosen;
      bit         reschedule;
      r = '0;
      r.next_priority = running_prio;
      reschedule = 1'b0;
      case (w.operation)
         OP_START: begin
            if (w.priority_req <= 6'd32 && !started_set[w.priority_req]) begin
               started_set[w.priority_req] = 1'b1;
               if (w.priority_req != 6'd0) begin
                  ready_set[w.priority_req - 6'd1] = 1'b1;
               end
               r.start_accepted = 1'b1;
            end
         end
         OP_BLOCK: begin
            if (running_known && running_prio != 6'd0) begin
               ticks_left[running_prio - 6'd1] = w.delay_ticks;
               ready_set[running_prio - 6'd1] = 1'b0;
               blocked_set[running_prio - 6'd1] = 1'b1;
               reschedule = 1'b1;
            end
         end
         OP_TICK: begin
            for (int i = 0; i < PRIO_SLOTS; i++) begin
               if (blocked_set[i]) begin
                  ticks_left[i] = ticks_left[i] - 32'd1;
                  if (ticks_left[i] == 32'd0) begin
                     blocked_set[i] = 1'b0;
                     ready_set[i] = 1'b1;
                  end
               end
            end
            reschedule = 1'b1;
         end
         default: begin
            reschedule = 1'b1;
         end
      endcase
      if (reschedule) begin
         chosen = 6'd0;
         for (int i = PRIO_SLOTS - 1; i >= 0; i--) begin
            if (ready_set[i] && chosen == 6'd0) begin
               chosen = 6'(i + 1);
            end
         end
         r.switch_request = !running_known || chosen != running_prio;
         running_prio = chosen;
         running_known = 1'b1;
         r.next_priority = chosen;
      end
      r.ready_bits = ready_set;
      r.blocked_bits = blocked_set;
      return r;
   endfunction

   task automatic queue_word(input logic [1:0] op, input int prio, input logic [31:0] ticks);
      req_type w;
      w.operation = op;
      w.priority_req = 6'(prio);
      w.delay_ticks = ticks;
      words_to_send.push_back(w);
   endtask

   function automatic int phase_now(input int sent);
      if (sent < total_words / 3) begin
         return 0;
      end else if (sent < 2 * total_words / 3) begin
         return 1;
      end
      return 2;
   endfunction

   always @(posedge clock) begin
      int phase;
      phase = phase_now(words_sent);
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            decisions_due.push_back(apply_operation(req_data));
            words_sent <= words_sent + 1;
         end
         if (!req_valid || !req_stall) begin
            if (words_to_send.size() != 0 &&
                $urandom_range(99, 0) >= (phase == 0 ? 19 : (phase == 1 ? 84 : 0))) begin
               req_data <= words_to_send.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      int phase;
      phase = phase_now(words_sent);
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (decisions_due.size() == 0) begin
               $error("result word with no decision waiting");
               failures++;
            end else begin
               due = decisions_due.pop_front();
               if (rsp_data.next_priority !== due.next_priority) begin
                  $error("next_priority: expected %0d, actual %0d",
                         due.next_priority, rsp_data.next_priority);
                  failures++;
               end
               if (rsp_data.switch_request !== due.switch_request) begin
                  $error("switch_request: expected %0b, actual %0b",
                         due.switch_request, rsp_data.switch_request);
                  failures++;
               end
               if (rsp_data.start_accepted !== due.start_accepted) begin
                  $error("start_accepted: expected %0b, actual %0b",
                         due.start_accepted, rsp_data.start_accepted);
                  failures++;
               end
               if (rsp_data.ready_bits !== due.ready_bits) begin
                  $error("ready_bits: expected %h, actual %h",
                         due.ready_bits, rsp_data.ready_bits);
                  failures++;
               end
               if (rsp_data.blocked_bits !== due.blocked_bits) begin
                  $error("blocked_bits: expected %h, actual %h",
                         due.blocked_bits, rsp_data.blocked_bits);
                  failures++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99, 0) < (phase == 0 ? 84 : (phase == 1 ? 19 : 0)));
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [1:0]  op;
      int          prio;
      logic [31:0] ticks;
      int          roll;

      // Scheduling, blocking and a tick before anything has started.
      queue_word(OP_SCHED, 0, 32'd0);
      queue_word(OP_BLOCK, 0, 32'd3);
      queue_word(OP_TICK, 0, 32'd0);
      // Idle may be started once only; priorities above the top are refused.
      queue_word(OP_START, 0, 32'd0);
      queue_word(OP_START, 0, 32'd0);
      queue_word(OP_START, 33, 32'd0);
      queue_word(OP_START, 63, 32'd0);
      queue_word(OP_START, 1, 32'd0);
      queue_word(OP_START, 32, 32'd0);
      queue_word(OP_START, 32, 32'd0);
      queue_word(OP_SCHED, 0, 32'd0);
      queue_word(OP_BLOCK, 0, 32'hFFFF_FFFF);
      queue_word(OP_START, 5, 32'd0);
      queue_word(OP_SCHED, 0, 32'd0);
      queue_word(OP_BLOCK, 0, 32'd1);
      queue_word(OP_TICK, 0, 32'd0);
      // A zero delay wraps round and keeps the thread parked.
      queue_word(OP_BLOCK, 0, 32'd0);
      queue_word(OP_TICK, 0, 32'd0);
      queue_word(OP_SCHED, 0, 32'd0);
      queue_word(OP_BLOCK, 0, 32'd2);
      queue_word(OP_BLOCK, 0, 32'd2);
      queue_word(OP_TICK, 0, 32'd0);
      queue_word(OP_TICK, 0, 32'd0);
      queue_word(OP_SCHED, 0, 32'd0);

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         roll = $urandom_range(99, 0);
         op = roll < 20 ? OP_START : (roll < 50 ? OP_BLOCK : (roll < 85 ? OP_TICK : OP_SCHED));
         prio = ($urandom_range(99, 0) < 85) ? $urandom_range(32, 0) : $urandom_range(63, 33);
         roll = $urandom_range(99, 0);
         if (roll < 1) begin
            ticks = 32'd0;
         end else if (roll < 2) begin
            ticks = $urandom();
         end else if (roll < 90) begin
            ticks = $urandom_range(6, 1);
         end else begin
            ticks = $urandom_range(40, 7);
         end
         queue_word(op, prio, ticks);
      end
      total_words = words_to_send.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (!timed_out &&
             (words_to_send.size() != 0 || req_valid || decisions_due.size() != 0)) begin
         @(posedge clock);
         if (quiet_cycles >= QUIET_LIMIT) begin
            timed_out = 1'b1;
         end
      end

      if (timed_out) begin
         $error("no word moved for %0d cycles", QUIET_LIMIT);
         $display("** priority_bitmap_scheduler_with_delays: FAILED **");
      end else begin
         repeat (DRAIN_CYCLES) @(posedge clock);
         if (decisions_due.size() != 0) begin
            $error("%0d decisions never arrived", decisions_due.size());
            failures++;
         end
         if (failures == 0) begin
            $display("** priority_bitmap_scheduler_with_delays: PASSED **");
         end else begin
            $display("** priority_bitmap_scheduler_with_delays: FAILED **");
         end
      end
      $finish;
   end

endmodule

// ----- priority_bitmap_scheduler_with_delays.f -----
sv/pbs_pkg.sv
sv/pbs_ram.sv
sv/priority_bitmap_scheduler_with_delays.sv
bench/tb.sv
